// File: hdl/bce_pkg.sv
package bce_pkg;

  localparam int DEPTH        = 4;   // samples averaged, 2..16
  localparam int SAMPLE_W     = 14;
  localparam int N_W          = $clog2(DEPTH + 1);
  localparam int SLOT_W       = $clog2(DEPTH);
  localparam int VAL_W        = SAMPLE_W + N_W;  // window sum and n * curve point
  localparam int QUOT_W       = 4;               // interpolation step is 0..10
  localparam int STEP_W       = $clog2(QUOT_W);
  localparam int REM_W        = VAL_W + QUOT_W;
  localparam int PCT_W        = 7;
  localparam int HELD_W       = 3;
  localparam int SEG_W        = 4;
  localparam int CURVE_POINTS = 11;
  localparam int LAST_SEG     = CURVE_POINTS - 2;

  localparam logic [PCT_W-1:0] PCT_FULL     = PCT_W'(100);
  localparam logic [PCT_W-1:0] PCT_PER_SEG  = PCT_W'(10);

  // Discharge curve knots in mV; knot k sits at k * 10 %.
  function automatic logic [SAMPLE_W-1:0] curve_mv(input logic [SEG_W-1:0] idx);
    logic [SAMPLE_W-1:0] mv;
    case (idx)
      SEG_W'(0):  mv = SAMPLE_W'(0);
      SEG_W'(1):  mv = SAMPLE_W'(9200);
      SEG_W'(2):  mv = SAMPLE_W'(9500);
      SEG_W'(3):  mv = SAMPLE_W'(9650);
      SEG_W'(4):  mv = SAMPLE_W'(9800);
      SEG_W'(5):  mv = SAMPLE_W'(9890);
      SEG_W'(6):  mv = SAMPLE_W'(9910);
      SEG_W'(7):  mv = SAMPLE_W'(9950);
      SEG_W'(8):  mv = SAMPLE_W'(10000);
      SEG_W'(9):  mv = SAMPLE_W'(10100);
      SEG_W'(10): mv = SAMPLE_W'(11100);
      default:    mv = SAMPLE_W'(0);
    endcase
    return mv;
  endfunction

  typedef struct packed {
    logic             valid;
    logic [VAL_W-1:0] sum;
    logic [N_W-1:0]   n;
  } sum_t;

  typedef struct packed {
    logic             valid;
    logic [PCT_W-1:0] pct;
    logic [N_W-1:0]   n;
  } result_t;

endpackage

// File: hdl/bce_if.sv
interface bce_in_if;
  logic                          valid;
  logic                          ready;
  logic [bce_pkg::SAMPLE_W-1:0] sample_mv;

  modport source (output valid, output sample_mv, input ready);
  modport sink   (input valid, input sample_mv, output ready);
endinterface

interface bce_out_if;
  logic                        valid;
  logic                        ready;
  logic [bce_pkg::PCT_W-1:0]  percent_remaining;
  logic [bce_pkg::HELD_W-1:0] samples_held;

  modport source (output valid, output percent_remaining, output samples_held, input ready);
  modport sink   (input valid, input percent_remaining, input samples_held, output ready);
endinterface

// File: hdl/bce_window.sv
module bce_window (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [bce_pkg::SAMPLE_W-1:0] sample,
  output bce_pkg::sum_t                 sum_out
);

  typedef enum logic [3:0] {
    W_IDLE = 4'b0001,
    W_READ = 4'b0010,
    W_ADD  = 4'b0100,
    W_DONE = 4'b1000
  } wstate_t;

  wstate_t state, state_next;

  logic [bce_pkg::SAMPLE_W-1:0] mem [bce_pkg::DEPTH];
  logic [bce_pkg::SAMPLE_W-1:0] rd_data;
  logic [bce_pkg::SLOT_W-1:0]   slot;
  logic [bce_pkg::SLOT_W-1:0]   rd_idx;
  logic [bce_pkg::N_W-1:0]      fill;
  logic [bce_pkg::VAL_W-1:0]    acc;
  logic                         last;

  assign last = (bce_pkg::N_W'(rd_idx) == (fill - bce_pkg::N_W'(1)));

  always_comb begin
    state_next = state;
    case (state)
      W_IDLE: if (start) state_next = W_READ;
      W_READ: state_next = W_ADD;
      W_ADD:  state_next = last ? W_DONE : W_READ;
      W_DONE: state_next = W_IDLE;
      default: state_next = W_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= W_IDLE;
      fill  <= '0;
      slot  <= '0;
    end else begin
      state <= state_next;
      if (state == W_IDLE && start) begin
        slot <= (slot == bce_pkg::SLOT_W'(bce_pkg::DEPTH - 1)) ? '0
                : slot + bce_pkg::SLOT_W'(1);
        if (fill != bce_pkg::N_W'(bce_pkg::DEPTH)) fill <= fill + bce_pkg::N_W'(1);
      end
    end
  end

  // sample store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (state == W_IDLE && start) mem[slot] <= sample;
    rd_data <= mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    case (state)
      W_IDLE: begin
        if (start) begin
          rd_idx <= '0;
          acc    <= '0;
        end
      end
      W_ADD: begin
        acc    <= acc + bce_pkg::VAL_W'(rd_data);
        rd_idx <= rd_idx + bce_pkg::SLOT_W'(1);
      end
      default: ;
    endcase
  end

  assign sum_out.valid = (state == W_DONE);
  assign sum_out.sum   = acc;
  assign sum_out.n     = fill;

endmodule

// File: hdl/bce_map.sv
module bce_map (
  input  logic             clk,
  input  logic             rst,
  input  bce_pkg::sum_t    sum_in,
  input  logic             take,
  output bce_pkg::result_t res
);

  typedef enum logic [4:0] {
    M_IDLE   = 5'b00001,
    M_SEARCH = 5'b00010,
    M_SCALE  = 5'b00100,
    M_DIV    = 5'b01000,
    M_DONE   = 5'b10000
  } mstate_t;

  mstate_t state, state_next;

  logic [bce_pkg::VAL_W-1:0]  sum_r, lo, hi, diff;
  logic [bce_pkg::N_W-1:0]    n_r;
  logic [bce_pkg::SEG_W-1:0]  seg;
  logic [bce_pkg::REM_W-1:0]  rem, divisor;
  logic [bce_pkg::QUOT_W-1:0] quot;
  logic [bce_pkg::STEP_W-1:0] step;
  logic [bce_pkg::PCT_W-1:0]  pct;
  logic                       in_seg, last_seg, last_step, ge;

  assign in_seg    = (sum_r <= hi);
  assign last_seg  = (seg == bce_pkg::SEG_W'(bce_pkg::LAST_SEG));
  assign last_step = (step == bce_pkg::STEP_W'(bce_pkg::QUOT_W - 1));
  assign ge        = (rem >= divisor);

  always_comb begin
    state_next = state;
    case (state)
      M_IDLE:   if (sum_in.valid) state_next = M_SEARCH;
      M_SEARCH: begin
        if (in_seg) state_next = M_SCALE;
        else if (last_seg) state_next = M_DONE;
      end
      M_SCALE:  state_next = M_DIV;
      M_DIV:    if (last_step) state_next = M_DONE;
      M_DONE:   if (take) state_next = M_IDLE;
      default:  state_next = M_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= M_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    case (state)
      M_IDLE: begin
        if (sum_in.valid) begin
          sum_r <= sum_in.sum;
          n_r   <= sum_in.n;
          seg   <= '0;
          lo    <= '0;
          hi    <= bce_pkg::VAL_W'(sum_in.n)
                   * bce_pkg::VAL_W'(bce_pkg::curve_mv(bce_pkg::SEG_W'(1)));
        end
      end
      M_SEARCH: begin
        if (in_seg) begin
          diff    <= sum_r - lo;
          divisor <= bce_pkg::REM_W'(hi - lo) << (bce_pkg::QUOT_W - 1);
        end else if (last_seg) begin
          pct <= bce_pkg::PCT_FULL;   // mean above the top knot
        end else begin
          lo  <= hi;
          hi  <= bce_pkg::VAL_W'(n_r)
                 * bce_pkg::VAL_W'(bce_pkg::curve_mv(seg + bce_pkg::SEG_W'(2)));
          seg <= seg + bce_pkg::SEG_W'(1);
        end
      end
      M_SCALE: begin
        rem  <= (bce_pkg::REM_W'(diff) << 3) + (bce_pkg::REM_W'(diff) << 1);
        quot <= '0;
        step <= '0;
      end
      M_DIV: begin
        // restoring divide, one quotient bit per cycle, divisor shifts right
        if (ge) rem <= rem - divisor;
        divisor <= divisor >> 1;
        quot    <= {quot[bce_pkg::QUOT_W-2:0], ge};
        step    <= step + bce_pkg::STEP_W'(1);
        if (last_step)
          pct <= bce_pkg::PCT_W'(seg) * bce_pkg::PCT_PER_SEG
                 + bce_pkg::PCT_W'({quot[bce_pkg::QUOT_W-2:0], ge});
      end
      default: ;
    endcase
  end

  assign res.valid = (state == M_DONE);
  assign res.pct   = pct;
  assign res.n     = n_r;

endmodule

// File: hdl/battery_charge_estimator.sv
// Battery charge estimator. Each word on sample_ch is one battery voltage
// sample in mV; each gives exactly one word on result_ch carrying the
// remaining charge in whole percent (truncated, 0..100) and the number of
// samples averaged (1..4). The mean of the last up to four samples is mapped
// through a fixed 11-knot discharge curve by linear interpolation; above
// 11100 mV the result is 100. One sample is in flight at a time: from
// acceptance to the result register the n held samples are summed from the
// window store (each read, then added, then the sum is handed on), the
// segment is searched one curve knot per cycle, the offset is scaled and
// divided bit-serially (skipped above the top knot), and the result is
// offered until the output register takes it. A new sample is accepted
// once the previous result has entered the output register, even if it has
// not yet been taken.
module battery_charge_estimator (
  input  logic      clk,
  input  logic      rst,
  bce_in_if.sink    sample_ch,
  bce_out_if.source result_ch
);

  bce_pkg::sum_t    win_sum;
  bce_pkg::result_t map_res;

  logic start;    // sample word accepted
  logic take;     // finished result moves into the output register
  logic busy;
  logic out_valid;
  logic [bce_pkg::PCT_W-1:0]  out_pct;
  logic [bce_pkg::HELD_W-1:0] out_held;

  assign sample_ch.ready = !busy;
  assign start           = sample_ch.valid && !busy;
  assign take            = map_res.valid && (!out_valid || result_ch.ready);

  // window store and running sum over the held samples
  bce_window u_window (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .sample  (sample_ch.sample_mv),
    .sum_out (win_sum)
  );

  // curve segment search and interpolation
  bce_map u_map (
    .clk    (clk),
    .rst    (rst),
    .sum_in (win_sum),
    .take   (take),
    .res    (map_res)
  );

  // busy from acceptance until the result is handed to the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (take) begin
      busy <= 1'b0;
    end
  end

  // output register: decouples the result word from a stalled sink
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (result_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_pct  <= map_res.pct;
      out_held <= bce_pkg::HELD_W'(map_res.n);   // reported modulo 8
    end
  end

  assign result_ch.valid             = out_valid;
  assign result_ch.percent_remaining = out_pct;
  assign result_ch.samples_held      = out_held;

endmodule

// File: hdl/bce_checker.sv
module bce_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [bce_pkg::PCT_W-1:0]  percent_remaining,
  input logic [bce_pkg::HELD_W-1:0] samples_held
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(percent_remaining)
                                && $stable(samples_held))
    else $error("result word changed while stalled");

  // percentage never exceeds full charge
  a_pct_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> percent_remaining <= bce_pkg::PCT_FULL)
    else $error("percent_remaining above 100");

  // one sample in flight: no acceptance in the cycle after one
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("sample accepted while busy");

  // no result straight out of reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid just after reset");

endmodule

bind battery_charge_estimator bce_checker u_bce_checker (
  .clk               (clk),
  .rst               (rst),
  .in_valid          (sample_ch.valid),
  .in_ready          (sample_ch.ready),
  .out_valid         (result_ch.valid),
  .out_ready         (result_ch.ready),
  .percent_remaining (result_ch.percent_remaining),
  .samples_held      (result_ch.samples_held)
);

// File: verif/battery_charge_estimator_tb.sv
`timescale 1ns / 1ps

// Testbench for battery_charge_estimator.
// A driver pops voltage words from a queue of pending samples and offers them
// on sample_ch; every accepted word goes through a local state-of-charge
// predictor (four-deep window, running fill count, piecewise-linear curve)
// whose result is queued. A monitor takes words from result_ch and checks
// them against the oldest queued prediction. The run passes through four
// idling phases: none, sender idle, receiver stalling, and both at once.
module battery_charge_estimator_tb;

  localparam int IDLE_LIMIT  = 5000;  // cycles with no word moving on either side
  localparam int DRAIN_WAIT  = 40;    // wait for a stray word after the drain
  localparam int RANDOM_PER_PHASE = 150;

  // Phases of the run, in order.
  typedef enum int {
    PH_STEADY,
    PH_SENDER_IDLE,
    PH_RECEIVER_STALL,
    PH_BOTH_IDLE
  } idle_phase_t;

  typedef struct {
    logic [bce_pkg::PCT_W-1:0]  pct;
    logic [bce_pkg::HELD_W-1:0] held;
  } charge_t;

  // Discharge curve knots in mV; knot k stands for k * 10 %.
  localparam int unsigned KNOT_MV [bce_pkg::CURVE_POINTS] = '{
    0, 9200, 9500, 9650, 9800, 9890, 9910, 9950, 10000, 10100, 11100
  };

  // Directed words; the first four also walk the fill count from 1 to 4.
  localparam logic [bce_pkg::SAMPLE_W-1:0] DIRECTED_MV [25] = '{
    14'd0, 14'd16383, 14'd16383, 14'd16383,     // extremes, all bits both ways
    14'd16383,                                  // full window, far above the curve
    14'd9200, 14'd9200, 14'd9200, 14'd9200,     // mean on a knot
    14'd11100, 14'd11100, 14'd11100, 14'd11100, // top knot exactly
    14'd11101,                                  // mean just past the top knot
    14'd11101, 14'd11101, 14'd11101,            // whole window above the curve
    14'd9100, 14'd9300, 14'd9200, 14'd9200,     // mixed samples, mean on a knot
    14'd9949, 14'd9951, 14'd0, 14'd4000         // mid-segment and low end
  };

  logic clk;
  logic rst;

  bce_in_if  sample_ch ();
  bce_out_if result_ch ();

  battery_charge_estimator dut (
    .clk       (clk),
    .rst       (rst),
    .sample_ch (sample_ch.sink),
    .result_ch (result_ch.source)
  );

  // Pending stimulus and predicted results.
  logic [bce_pkg::SAMPLE_W-1:0] pending_mv [$];
  charge_t                      expected_charge [$];

  // Predictor state: the sample window, its fill level and the next slot.
  logic [bce_pkg::SAMPLE_W-1:0] window_mv [bce_pkg::DEPTH];
  int unsigned                  window_fill = 0;
  int unsigned                  window_slot = 0;

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int          quiet_cycles;
  int          error_count = 0;
  bit          timed_out;
  logic [bce_pkg::SAMPLE_W-1:0] last_mv;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Mean of the window mapped through the curve, exact integer form:
  // first segment with n*v1 <= sum <= n*v2 wins; above the top knot is 100 %.
  function automatic int unsigned soc_percent(input int unsigned sum, input int unsigned n);
    int unsigned lo;
    int unsigned hi;
    for (int k = 0; k < bce_pkg::CURVE_POINTS - 1; k++) begin
      lo = n * KNOT_MV[k];
      hi = n * KNOT_MV[k + 1];
      if (sum >= lo && sum <= hi)
        return 10 * k + (10 * (sum - lo)) / (hi - lo);
    end
    return 100;
  endfunction

  // An accepted sample: update the window and queue the expected charge.
  task automatic log_sample(input logic [bce_pkg::SAMPLE_W-1:0] mv);
    int unsigned sum;
    charge_t     exp_word;
    window_mv[window_slot] = mv;
    window_slot = (window_slot + 1) % bce_pkg::DEPTH;
    if (window_fill < bce_pkg::DEPTH)
      window_fill++;
    sum = 0;
    for (int k = 0; k < window_fill; k++)
      sum += window_mv[k];
    exp_word.pct  = bce_pkg::PCT_W'(soc_percent(sum, window_fill));
    exp_word.held = bce_pkg::HELD_W'(window_fill);
    expected_charge.insert(expected_charge.size(), exp_word);
  endtask

  // Random sample, weighted towards the steep part of the curve: mostly the
  // 9.1 V to 11.2 V band, some right on or beside a knot, runs of repeats so
  // the mean lands on knots exactly, and the odd value from the full range.
  function automatic logic [bce_pkg::SAMPLE_W-1:0] pick_sample();
    int unsigned roll;
    int          mv;
    roll = $urandom_range(99, 0);
    if (roll < 45)
      mv = $urandom_range(11200, 9100);
    else if (roll < 70)
      mv = int'(KNOT_MV[$urandom_range(bce_pkg::CURVE_POINTS - 1, 1)])
           + $urandom_range(6, 0) - 3;
    else if (roll < 85)
      mv = int'(last_mv);
    else
      mv = $urandom_range((1 << bce_pkg::SAMPLE_W) - 1, 0);
    last_mv = bce_pkg::SAMPLE_W'(mv);
    return bce_pkg::SAMPLE_W'(mv);
  endfunction

  // Driver: one word in flight on sample_ch, refilled from pending_mv.
  always @(posedge clk) begin
    if (rst) begin
      sample_ch.valid     <= 1'b0;
      sample_ch.sample_mv <= '0;
    end else if (!sample_ch.valid || sample_ch.ready) begin
      if (sample_ch.valid)
        log_sample(sample_ch.sample_mv);
      if (pending_mv.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
        sample_ch.valid     <= 1'b1;
        sample_ch.sample_mv <= pending_mv[0];
        pending_mv.delete(0);
      end else begin
        sample_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: random back-pressure, then field-by-field check on each word taken.
  always @(posedge clk) begin
    charge_t exp_word;
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (expected_charge.size() == 0) begin
          $error("result word with nothing expected: percent_remaining %0d, samples_held %0d",
                 result_ch.percent_remaining, result_ch.samples_held);
          error_count++;
        end else begin
          exp_word = expected_charge[0];
          expected_charge.delete(0);
          if (result_ch.percent_remaining !== exp_word.pct) begin
            $error("percent_remaining: expected %0d, got %0d",
                   exp_word.pct, result_ch.percent_remaining);
            error_count++;
          end
          if (result_ch.samples_held !== exp_word.held) begin
            $error("samples_held: expected %0d, got %0d",
                   exp_word.held, result_ch.samples_held);
            error_count++;
          end
        end
      end
      result_ch.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end
  end

  // Watchdog count: cycles in which neither channel moves a word.
  always @(posedge clk) begin
    if (rst || (sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  assign timed_out = (quiet_cycles >= IDLE_LIMIT);

  // Load one idling phase and wait until its samples have all gone in.
  task automatic run_phase(input idle_phase_t phase, input int count);
    case (phase)
      PH_STEADY: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      PH_SENDER_IDLE: begin
        send_idle_pct  = 51;
        recv_stall_pct = 0;
      end
      PH_RECEIVER_STALL: begin
        send_idle_pct  = 0;
        recv_stall_pct = 51;
      end
      default: begin
        send_idle_pct  = 12;
        recv_stall_pct = 12;
      end
    endcase
    for (int k = 0; k < count; k++)
      pending_mv.insert(pending_mv.size(), pick_sample());
    while (!timed_out && (pending_mv.size() > 0 || sample_ch.valid))
      @(posedge clk);
  endtask

  initial begin
    rst            = 1'b1;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    last_mv        = bce_pkg::SAMPLE_W'(10000);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED_MV[k])
      pending_mv.insert(pending_mv.size(), DIRECTED_MV[k]);
    run_phase(PH_STEADY, RANDOM_PER_PHASE);
    run_phase(PH_SENDER_IDLE, RANDOM_PER_PHASE);
    run_phase(PH_RECEIVER_STALL, RANDOM_PER_PHASE);
    run_phase(PH_BOTH_IDLE, RANDOM_PER_PHASE);

    // Drain outstanding results, then give a stray word time to appear.
    while (!timed_out && expected_charge.size() > 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (timed_out || expected_charge.size() > 0) begin
      $display("battery_charge_estimator_tb NOT OK");
    end else if (error_count == 0) begin
      $display("battery_charge_estimator_tb OK");
    end else begin
      $display("battery_charge_estimator_tb NOT OK");
    end
    $finish;
  end

endmodule
